### rtl/olae_pkg.sv
// Shared types and codes for the ordered array list engine.
package olae_pkg;

    typedef enum logic [2:0] {
        KIND_APPEND     = 3'd0,
        KIND_INSERT_AT  = 3'd1,
        KIND_REMOVE_KEY = 3'd2,
        KIND_REMOVE_AT  = 3'd3,
        KIND_READ_AT    = 3'd4,
        KIND_CLEAR      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_BAD_POS = 2'd2,
        STATUS_NO_KEY  = 2'd3
    } status_t;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int SIZE_W = 8;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic             ins;     // open a slot at pos, shift upper cells up
        logic             rm_at;   // close the slot at pos, shift upper cells down
        logic             rm_key;  // close the first matching slot
        logic [KEY_W-1:0] new_key;
        logic [VAL_W-1:0] new_val;
    } cell_ctl_t;

endpackage

### rtl/olae_cell.sv
// One slot of the list: holds an entry, compares its key and shifts with its neighbours.
module olae_cell #(
    parameter int INDEX = 0,
    parameter int CMP_W = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  olae_pkg::cell_ctl_t        ctl,
    input  logic [CMP_W-1:0]           pos,
    input  logic [CMP_W-1:0]           count,
    input  logic [olae_pkg::KEY_W-1:0] probe_key,
    input  logic [olae_pkg::KEY_W-1:0] left_key,
    input  logic [olae_pkg::VAL_W-1:0] left_val,
    input  logic [olae_pkg::KEY_W-1:0] right_key,
    input  logic [olae_pkg::VAL_W-1:0] right_val,
    output logic [olae_pkg::KEY_W-1:0] cell_key,
    output logic [olae_pkg::VAL_W-1:0] cell_val,
    input  logic                       prefix_in,
    output logic                       prefix_out,
    input  logic [olae_pkg::KEY_W-1:0] rd_key_in,
    input  logic [olae_pkg::VAL_W-1:0] rd_val_in,
    output logic [olae_pkg::KEY_W-1:0] rd_key_out,
    output logic [olae_pkg::VAL_W-1:0] rd_val_out
);
    import olae_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic             match_reg;
    logic             sel;
    logic             shift_down;

    assign sel        = (pos == MY_IDX);
    // match at this slot or any below it
    assign prefix_out = prefix_in | match_reg;
    assign shift_down = (ctl.rm_at && (MY_IDX >= pos)) || (ctl.rm_key && prefix_out);

    assign rd_key_out = rd_key_in | (sel ? key_reg : '0);
    assign rd_val_out = rd_val_in | (sel ? val_reg : '0);
    assign cell_key   = key_reg;
    assign cell_val   = val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= (key_reg == probe_key) && (MY_IDX < count);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ins) begin
            if (sel) begin
                key_reg <= ctl.new_key;
                val_reg <= ctl.new_val;
            end else if (MY_IDX > pos) begin
                key_reg <= left_key;
                val_reg <= left_val;
            end
        end else if (shift_down) begin
            key_reg <= right_key;
            val_reg <= right_val;
        end
    end

endmodule

### rtl/ordered_array_list_engine.sv
// Top level of the ordered array list engine: controller and chain of slot cells.
//
//  channel | ports                      | contents
//  --------+----------------------------+-----------------------------------------
//  input   | s_tvalid s_tready s_tdata  | one operation per transfer, kind on tuser
//          | s_tuser                    |
//  result  | m_tvalid m_tready m_tdata  | status, size and read data, one per input
//
// The accepting edge latches an operation and lets every cell register its key
// compare; the next edge applies the shift or read and loads the result register.
// Reset (aresetn low, synchronous) empties the list; entry contents are left as is.
// A new transfer is taken only in idle when the result register is free or
// drains at the same edge, so a stalled result holds one operation back.
module ordered_array_list_engine #(
    parameter int CAPACITY = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // entry_key[63:0], entry_value[95:64], position[103:96]
    input  logic [2:0]   s_tuser,  // kind[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata   // status[1:0], list_size[9:2], read_key[73:10],
                                   // read_value[105:74], zero pad[111:106]
);
    import olae_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [2:0]       kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [POS_W-1:0] pos_reg;

    logic             m_tvalid_reg;
    logic [1:0]       status_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [KEY_W-1:0] rkey_reg;
    logic [VAL_W-1:0] rval_reg;

    logic             s_accept;
    logic             exec;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_eff;
    logic             full;
    logic             found;
    logic             rd_ok;
    status_t          status_next;
    logic [CNT_W-1:0] count_next;
    cell_ctl_t        ctl;

    logic [KEY_W-1:0] cell_key [CAPACITY];
    logic [VAL_W-1:0] cell_val [CAPACITY];
    logic             prefix   [CAPACITY+1];
    logic [KEY_W-1:0] rd_key   [CAPACITY+1];
    logic [VAL_W-1:0] rd_val   [CAPACITY+1];

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign exec     = (state_reg == ST_EXEC);

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (count_reg == CAP_CNT);
    assign found   = prefix[CAPACITY];

    // Decode the latched operation; cells see it only in the execute cycle.
    always_comb begin
        status_next = STATUS_OK;
        count_next  = count_reg;
        pos_eff     = pos_ext;
        rd_ok       = 1'b0;
        ctl.ins     = 1'b0;
        ctl.rm_at   = 1'b0;
        ctl.rm_key  = 1'b0;
        ctl.new_key = key_reg;
        ctl.new_val = val_reg;
        case (kind_reg)
            KIND_APPEND: begin
                pos_eff = cnt_ext;
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ctl.ins    = exec;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_INSERT_AT: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else if (pos_ext > cnt_ext) begin
                    status_next = STATUS_BAD_POS;
                end else begin
                    ctl.ins    = exec;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_REMOVE_KEY: begin
                ctl.rm_key = exec;
                if (found) begin
                    count_next = count_reg - 1'b1;
                end else begin
                    status_next = STATUS_NO_KEY;
                end
            end
            KIND_REMOVE_AT: begin
                if (pos_ext >= cnt_ext) begin
                    status_next = STATUS_BAD_POS;
                end else begin
                    ctl.rm_at  = exec;
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_READ_AT: begin
                if (pos_ext >= cnt_ext) begin
                    status_next = STATUS_BAD_POS;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            KIND_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    // Chain of slots; bottom neighbour of slot 0 is unused, top neighbour of the last is tied to zero.
    assign prefix[0] = 1'b0;
    assign rd_key[0] = '0;
    assign rd_val[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_W-1:0] lk;
        logic [VAL_W-1:0] lv;
        logic [KEY_W-1:0] rk;
        logic [VAL_W-1:0] rv;

        if (i == 0) begin : g_lo
            assign lk = key_reg;
            assign lv = val_reg;
        end else begin : g_lo
            assign lk = cell_key[i-1];
            assign lv = cell_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_hi
            assign rk = '0;
            assign rv = '0;
        end else begin : g_hi
            assign rk = cell_key[i+1];
            assign rv = cell_val[i+1];
        end

        olae_cell #(
            .INDEX (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .pos        (pos_eff),
            .count      (cnt_ext),
            .probe_key  (s_tdata[63:0]),
            .left_key   (lk),
            .left_val   (lv),
            .right_key  (rk),
            .right_val  (rv),
            .cell_key   (cell_key[i]),
            .cell_val   (cell_val[i]),
            .prefix_in  (prefix[i]),
            .prefix_out (prefix[i+1]),
            .rd_key_in  (rd_key[i]),
            .rd_val_in  (rd_val[i]),
            .rd_key_out (rd_key[i+1]),
            .rd_val_out (rd_val[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        kind_reg  <= s_tuser;
                        key_reg   <= s_tdata[63:0];
                        val_reg   <= s_tdata[95:64];
                        pos_reg   <= s_tdata[103:96];
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    count_reg    <= count_next;
                    m_tvalid_reg <= 1'b1;
                    status_reg   <= status_next;
                    size_reg     <= SIZE_W'(count_next);
                    rkey_reg     <= rd_ok ? rd_key[CAPACITY] : '0;
                    rval_reg     <= rd_ok ? rd_val[CAPACITY] : '0;
                    state_reg    <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, rval_reg, rkey_reg, size_reg, status_reg};

    // Fill level never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // Every accepted operation is executed on the next edge.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_EXEC))
        else $error("accepted operation not executed");

    // The execute cycle always loads a result.
    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec |=> m_tvalid_reg)
        else $error("execute cycle left no result");

    // A full report only comes from a full list.
    a_full_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (status_reg == STATUS_FULL)) |-> (size_reg == SIZE_W'(CAP_CNT)))
        else $error("full status with list not full");

    // The list never changes outside the execute cycle.
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> $stable(count_reg))
        else $error("entry count changed while idle");

endmodule
